@@ design/mh_pkg.sv @@
// Shared constants, register codes and the arctangent table for the magnetometer heading block.
`timescale 1ns / 1ps
`default_nettype none

package mh_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int SAMPLE_BITS_DEF   = 16;

	// angle word inside the CORDIC, Q.30 radians
	localparam int ZW         = 35;
	localparam int Z_SHIFT    = 18;
	localparam int ANGLE_W    = 15;
	localparam int RAW_W      = 16;
	localparam int OUT_TDATA_W = 32;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic signed [ZW-1:0]      PI_Q30     = 35'sd3373259426;
	localparam logic signed [ZW-1:0]      Z_ROUND    = 35'sd131072;
	localparam logic signed [ANGLE_W-1:0] PI_Q12     = 15'sd12868;
	localparam logic signed [RAW_W-1:0]   TWO_PI_Q12 = 16'sd25736;

	localparam logic signed [15:0]        OFFSET_X_RST = -16'sd410;
	localparam logic signed [15:0]        OFFSET_Y_RST = -16'sd5038;
	localparam logic [15:0]               SCALE_X_RST  = 16'd26808;
	localparam logic [15:0]               SCALE_Y_RST  = 16'd16931;
	localparam logic signed [ANGLE_W-1:0] MOUNT_ANGLE_RST = 15'sd7660;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_OFFSET_X    = 3'd0,
		REG_OFFSET_Y    = 3'd1,
		REG_SCALE_X     = 3'd2,
		REG_SCALE_Y     = 3'd3,
		REG_MOUNT_ANGLE = 3'd4
	} cfg_reg_t;

	// atan(2^-i) in Q.30, truncated
	function automatic logic signed [ZW-1:0] atan_q30(input int idx);
		logic signed [ZW-1:0] r;
		case (idx)
			0:       r = 35'sh03243F6A8;
			1:       r = 35'sh01DAC6705;
			2:       r = 35'sh00FADBAFC;
			3:       r = 35'sh007F56EA6;
			4:       r = 35'sh003FEAB76;
			5:       r = 35'sh001FFD55B;
			6:       r = 35'sh000FFFAAA;
			7:       r = 35'sh0007FFF55;
			8:       r = 35'sh0003FFFEA;
			9:       r = 35'sh0001FFFFD;
			10:      r = 35'sh0000FFFFF;
			11:      r = 35'sh00007FFFF;
			12:      r = 35'sh00003FFFF;
			13:      r = 35'sh00001FFFF;
			14:      r = 35'sh00000FFFF;
			15:      r = 35'sh000007FFF;
			16:      r = 35'sh000003FFF;
			17:      r = 35'sh000001FFF;
			18:      r = 35'sh000000FFF;
			19:      r = 35'sh0000007FF;
			20:      r = 35'sh0000003FF;
			21:      r = 35'sh0000001FF;
			22:      r = 35'sh0000000FF;
			23:      r = 35'sh00000007F;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ design/mh_front.sv @@
// Iron correction and quadrant pre-rotation ahead of the CORDIC cells.
`timescale 1ns / 1ps
`default_nettype none

module mh_front import mh_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int CW          = 59
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] mag_x,
	input  wire logic signed [SAMPLE_BITS-1:0] mag_y,
	input  wire logic signed [15:0]            offset_x,
	input  wire logic signed [15:0]            offset_y,
	input  wire logic [15:0]                   scale_x,
	input  wire logic [15:0]                   scale_y,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [CW-1:0]               out_x,
	output logic signed [CW-1:0]               out_y,
	output logic signed [ZW-1:0]               out_z,
	output logic                               out_zero
);

	localparam int DW  = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 1;
	localparam int PW  = DW + 16;
	localparam int PRE = 40 - SAMPLE_BITS;

	logic                 valid_s1, valid_s2, valid_s3;
	logic                 rdy1, rdy2, rdy3;
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic signed [PW-1:0] px_s2, py_s2;
	logic signed [CW-1:0] xe, ye;
	logic signed [CW-1:0] x_s3, y_s3;
	logic signed [ZW-1:0] z_s3;
	logic                 zero_s3;

	assign rdy3     = !valid_s3 || out_ready;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_ready = rdy1;

	assign xe = CW'(px_s2) <<< PRE;
	assign ye = CW'(py_s2) <<< PRE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			dx_s1 <= DW'(mag_x) - DW'(offset_x);
			dy_s1 <= DW'(mag_y) - DW'(offset_y);
		end
		if (rdy2) begin
			px_s2 <= PW'(dx_s1) * PW'($signed({1'b0, scale_x}));
			py_s2 <= PW'(dy_s1) * PW'($signed({1'b0, scale_y}));
		end
		if (rdy3) begin
			zero_s3 <= (px_s2 == '0) && (py_s2 == '0);
			// left half-plane: turn by pi
			if (xe < 0) begin
				x_s3 <= -xe;
				y_s3 <= -ye;
				z_s3 <= (ye >= 0) ? PI_Q30 : -PI_Q30;
			end else begin
				x_s3 <= xe;
				y_s3 <= ye;
				z_s3 <= '0;
			end
		end
	end

	assign out_valid = valid_s3;
	assign out_x     = x_s3;
	assign out_y     = y_s3;
	assign out_z     = z_s3;
	assign out_zero  = zero_s3;

endmodule

`default_nettype wire

@@ design/mh_cordic_cell.sv @@
// One vectoring CORDIC micro-rotation with its own pipeline register.
`timescale 1ns / 1ps
`default_nettype none

module mh_cordic_cell import mh_pkg::*; #(
	parameter int CW    = 59,
	parameter int STAGE = 0
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic signed [CW-1:0] in_x,
	input  wire logic signed [CW-1:0] in_y,
	input  wire logic signed [ZW-1:0] in_z,
	input  wire logic                 in_zero,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic signed [CW-1:0]      out_x,
	output logic signed [CW-1:0]      out_y,
	output logic signed [ZW-1:0]      out_z,
	output logic                      out_zero
);

	localparam logic signed [ZW-1:0] ATAN = atan_q30(STAGE);

	logic                 valid_s1;
	logic                 zero_s1;
	logic signed [CW-1:0] x_s1, y_s1;
	logic signed [ZW-1:0] z_s1;
	logic signed [CW-1:0] xs, ys, nx, ny;
	logic signed [ZW-1:0] nz;

	assign in_ready = !valid_s1 || out_ready;

	always_comb begin
		xs = in_x >>> STAGE;
		ys = in_y >>> STAGE;
		if (in_y > 0) begin
			nx = in_x + ys;
			ny = in_y - xs;
			nz = in_z + ATAN;
		end else begin
			nx = in_x - ys;
			ny = in_y + xs;
			nz = in_z - ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			x_s1    <= nx;
			y_s1    <= ny;
			z_s1    <= nz;
			zero_s1 <= in_zero;
		end
	end

	assign out_valid = valid_s1;
	assign out_x     = x_s1;
	assign out_y     = y_s1;
	assign out_z     = z_s1;
	assign out_zero  = zero_s1;

endmodule

`default_nettype wire

@@ design/mh_finish.sv @@
// Angle rounding and clamping, mounting offset and wrap into (-pi, pi].
`timescale 1ns / 1ps
`default_nettype none

module mh_finish import mh_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic signed [ZW-1:0]      in_z,
	input  wire logic                      in_zero,
	input  wire logic signed [ANGLE_W-1:0] mount_angle,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic signed [ANGLE_W-1:0]      heading_wrapped,
	output logic signed [RAW_W-1:0]        heading_raw
);

	localparam int AW = ZW - Z_SHIFT;

	logic                      valid_s1, valid_s2;
	logic                      rdy1, rdy2;
	logic signed [ZW-1:0]      zr;
	logic signed [AW-1:0]      ar;
	logic signed [ANGLE_W-1:0] ac;
	logic signed [ANGLE_W-1:0] a_s1;
	logic signed [RAW_W-1:0]   raw;
	logic signed [RAW_W-1:0]   wr;
	logic signed [ANGLE_W-1:0] wrapped_s2;
	logic signed [RAW_W-1:0]   raw_s2;

	assign rdy2     = !valid_s2 || out_ready;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		zr = in_z + Z_ROUND;
		ar = $signed(zr[ZW-1:Z_SHIFT]);
		if (in_zero) begin
			ac = '0;
		end else if (ar > PI_Q12) begin
			ac = PI_Q12;
		end else if (ar < -PI_Q12) begin
			ac = -PI_Q12;
		end else begin
			ac = ar[ANGLE_W-1:0];
		end
	end

	always_comb begin
		raw = RAW_W'(a_s1) - RAW_W'(mount_angle);
		if (raw > RAW_W'(PI_Q12)) begin
			wr = raw - TWO_PI_Q12;
		end else if (raw <= -RAW_W'(PI_Q12)) begin
			wr = raw + TWO_PI_Q12;
		end else begin
			wr = raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) a_s1 <= ac;
		if (rdy2) begin
			raw_s2     <= raw;
			wrapped_s2 <= wr[ANGLE_W-1:0];
		end
	end

	assign out_valid       = valid_s2;
	assign heading_wrapped = wrapped_s2;
	assign heading_raw     = raw_s2;

endmodule

`default_nettype wire

@@ design/magnetometer_heading.sv @@
// Top level of the magnetometer compass heading pipeline.
//
//  channel   | direction | handshake                   | payload
//  s_axis    | in        | s_axis_tvalid/s_axis_tready | mag_x, mag_y
//  m_axis    | out       | m_axis_tvalid/m_axis_tready | heading_wrapped, heading_raw
//  cfg       | in        | cfg_wen (no wait)           | cfg_index, cfg_data
//
// One transaction is taken per cycle while the output is not stalled; the pipeline
// holds three correction stages, one cell per micro-rotation and two finishing stages.
// Every stage holds its own valid bit, so bubbles close up under a stall and a
// held result never blocks stages behind it that are empty.
// Reset clears the valid bits and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module magnetometer_heading import mh_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int IN_TDATA_W    = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // mag_x, mag_y, zero pad
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // heading_wrapped, heading_raw, zero pad
	input  wire logic                   cfg_wen,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int DW = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 1;
	localparam int CW = DW + 16 + (40 - SAMPLE_BITS) + 2;

	logic signed [15:0]         offset_x_q, offset_y_q;
	logic [15:0]                scale_x_q, scale_y_q;
	logic signed [ANGLE_W-1:0]  mount_angle_q;

	logic signed [CW-1:0] cx [CORDIC_STAGES+1];
	logic signed [CW-1:0] cy [CORDIC_STAGES+1];
	logic signed [ZW-1:0] cz [CORDIC_STAGES+1];
	logic                 czero [CORDIC_STAGES+1];
	logic                 cvalid [CORDIC_STAGES+1];
	logic                 cready [CORDIC_STAGES+1];

	logic signed [ANGLE_W-1:0] heading_wrapped;
	logic signed [RAW_W-1:0]   heading_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q    <= OFFSET_X_RST;
			offset_y_q    <= OFFSET_Y_RST;
			scale_x_q     <= SCALE_X_RST;
			scale_y_q     <= SCALE_Y_RST;
			mount_angle_q <= MOUNT_ANGLE_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_OFFSET_X:    offset_x_q    <= $signed(cfg_data);
				REG_OFFSET_Y:    offset_y_q    <= $signed(cfg_data);
				REG_SCALE_X:     scale_x_q     <= cfg_data;
				REG_SCALE_Y:     scale_y_q     <= cfg_data;
				REG_MOUNT_ANGLE: mount_angle_q <= $signed(cfg_data[ANGLE_W-1:0]);
				default: ;
			endcase
		end
	end

	mh_front #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.CW         (CW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.mag_x    ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
		.mag_y    ($signed(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
		.offset_x (offset_x_q),
		.offset_y (offset_y_q),
		.scale_x  (scale_x_q),
		.scale_y  (scale_y_q),
		.out_valid(cvalid[0]),
		.out_ready(cready[0]),
		.out_x    (cx[0]),
		.out_y    (cy[0]),
		.out_z    (cz[0]),
		.out_zero (czero[0])
	);

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		mh_cordic_cell #(
			.CW   (CW),
			.STAGE(g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (cvalid[g]),
			.in_ready (cready[g]),
			.in_x     (cx[g]),
			.in_y     (cy[g]),
			.in_z     (cz[g]),
			.in_zero  (czero[g]),
			.out_valid(cvalid[g+1]),
			.out_ready(cready[g+1]),
			.out_x    (cx[g+1]),
			.out_y    (cy[g+1]),
			.out_z    (cz[g+1]),
			.out_zero (czero[g+1])
		);
	end

	mh_finish u_finish (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (cvalid[CORDIC_STAGES]),
		.in_ready       (cready[CORDIC_STAGES]),
		.in_z           (cz[CORDIC_STAGES]),
		.in_zero        (czero[CORDIC_STAGES]),
		.mount_angle    (mount_angle_q),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.heading_wrapped(heading_wrapped),
		.heading_raw    (heading_raw)
	);

	assign m_axis_tdata = {1'b0, heading_raw, heading_wrapped};

	// input may only stall when a result is held at the output
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled with output free");

	a_wrap_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (heading_wrapped > -PI_Q12) && (heading_wrapped <= PI_Q12))
		else $error("wrapped heading out of range");

	a_wrap_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (17'(heading_raw) == 17'(heading_wrapped)) ||
			(17'(heading_raw) == 17'(heading_wrapped) + 17'(TWO_PI_Q12)) ||
			(17'(heading_raw) == 17'(heading_wrapped) - 17'(TWO_PI_Q12)))
		else $error("wrapped and raw heading differ by more than one turn");

endmodule

`default_nettype wire

@@ bench/tb_magnetometer_heading.sv @@
// Self-checking testbench for the magnetometer heading pipeline.
`timescale 1ns / 1ps

module tb_magnetometer_heading;
	import mh_pkg::*;

	localparam int ROTATIONS    = CORDIC_STAGES_DEF;
	localparam int PRE_SHIFT    = 40 - SAMPLE_BITS_DEF;
	localparam int LATENCY      = CORDIC_STAGES_DEF + 5;
	localparam int IDLE_LIMIT   = 4000;

	localparam longint HALF_TURN_Q30 = 64'sd3373259426;
	localparam longint HALF_TURN_Q12 = 64'sd12868;
	localparam longint FULL_TURN_Q12 = 64'sd25736;

	// atan(2^-i), Q.30, truncated
	localparam longint ARCTAN_Q30 [24] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
		64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
		64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
		64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
		64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
	};

	typedef struct packed {
		logic signed [14:0] wrapped;
		logic signed [15:0] raw;
	} heading_t;

	class heading_checker;
		heading_t           headings_due[$];
		logic signed [15:0] off_x;
		logic signed [15:0] off_y;
		logic [15:0]        gain_x;
		logic [15:0]        gain_y;
		logic signed [14:0] mount;
		int                 errors;

		function new();
			off_x  = OFFSET_X_RST;
			off_y  = OFFSET_Y_RST;
			gain_x = SCALE_X_RST;
			gain_y = SCALE_Y_RST;
			mount  = MOUNT_ANGLE_RST;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
			case (idx)
				REG_OFFSET_X:    off_x  = val;
				REG_OFFSET_Y:    off_y  = val;
				REG_SCALE_X:     gain_x = val;
				REG_SCALE_Y:     gain_y = val;
				REG_MOUNT_ANGLE: mount  = val[14:0];
				default: ;
			endcase
		endfunction

		function longint cordic_angle(longint cx, longint cy);
			longint x;
			longint y;
			longint z;
			longint nx;
			longint ny;
			longint a;
			if (cx == 0 && cy == 0)
				return 0;
			x = cx <<< PRE_SHIFT;
			y = cy <<< PRE_SHIFT;
			z = 0;
			if (x < 0) begin
				z = (y >= 0) ? HALF_TURN_Q30 : -HALF_TURN_Q30;
				x = -x;
				y = -y;
			end
			for (int i = 0; i < ROTATIONS; i++) begin
				if (y > 0) begin
					nx = x + (y >>> i);
					ny = y - (x >>> i);
					z  = z + ARCTAN_Q30[i];
				end else begin
					nx = x - (y >>> i);
					ny = y + (x >>> i);
					z  = z - ARCTAN_Q30[i];
				end
				x = nx;
				y = ny;
			end
			a = (z + (64'sd1 <<< 17)) >>> 18;
			if (a > HALF_TURN_Q12)
				a = HALF_TURN_Q12;
			if (a < -HALF_TURN_Q12)
				a = -HALF_TURN_Q12;
			return a;
		endfunction

		function void note_sample(logic signed [15:0] mx, logic signed [15:0] my);
			longint   cx;
			longint   cy;
			longint   raw;
			longint   wr;
			heading_t h;
			cx  = (longint'(mx) - longint'(off_x)) * longint'(gain_x);
			cy  = (longint'(my) - longint'(off_y)) * longint'(gain_y);
			raw = cordic_angle(cx, cy) - longint'(mount);
			wr  = raw;
			if (wr > HALF_TURN_Q12)
				wr = wr - FULL_TURN_Q12;
			else if (wr <= -HALF_TURN_Q12)
				wr = wr + FULL_TURN_Q12;
			h.wrapped = wr[14:0];
			h.raw     = raw[15:0];
			headings_due.push_back(h);
		endfunction

		function void report(string field, longint want, longint got);
			errors++;
			$display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
		endfunction

		function void check_heading(logic [OUT_TDATA_W-1:0] tdata);
			heading_t           want;
			logic signed [14:0] got_wrapped;
			logic signed [15:0] got_raw;
			got_wrapped = tdata[14:0];
			got_raw     = tdata[30:15];
			if (headings_due.size() == 0) begin
				report("unexpected transaction, tdata", 0, longint'(tdata));
				return;
			end
			want = headings_due.pop_front();
			if (got_wrapped !== want.wrapped)
				report("heading_wrapped", longint'(want.wrapped), longint'(got_wrapped));
			if (got_raw !== want.raw)
				report("heading_raw", longint'(want.raw), longint'(got_raw));
			if (tdata[31] !== 1'b0)
				report("tdata pad", 0, longint'(tdata[31]));
		endfunction

		function int pending();
			return headings_due.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [31:0]            s_axis_tdata;  // mag_x, mag_y
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;  // heading_wrapped, heading_raw, zero pad
	logic                   cfg_wen;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	heading_checker sb;
	logic           rush;
	int             rx_stall;
	int             rx_draw;
	int             idle_cycles;

	magnetometer_heading u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// result side: random back-pressure, none while rushing
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_stall      <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			sb.check_heading(m_axis_tdata);
			rx_draw = rush ? 0 : $urandom_range(0, 5);
			rx_stall      <= rx_draw;
			m_axis_tready <= (rx_draw == 0);
		end else if (rx_stall > 0) begin
			rx_stall      <= rx_stall - 1;
			m_axis_tready <= (rx_stall == 1);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_magnetometer_heading: errors");
				$finish;
			end
		end
	end

	task automatic send_sample(input logic [15:0] mx, input logic [15:0] my);
		int gap;
		gap = rush ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {my, mx};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_sample(mx, my);
	endtask

	// hold off until the pipeline is empty
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic random_sample();
		int kind;
		int tx;
		int ty;
		kind = $urandom_range(0, 7);
		tx   = $urandom;
		ty   = $urandom;
		case (kind)
			3, 4: begin
				tx = int'(sb.off_x) + $urandom_range(0, 128) - 64;
				ty = int'(sb.off_y) + $urandom_range(0, 128) - 64;
			end
			5: tx = int'(sb.off_x);
			6: ty = int'(sb.off_y);
			7: begin
				tx = int'(sb.off_x) + $urandom_range(0, 4) - 2;
				ty = int'(sb.off_y) + $urandom_range(0, 4) - 2;
			end
			default: ;
		endcase
		send_sample(tx[15:0], ty[15:0]);
	endtask

	task automatic random_run(input int n);
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0)
				rush <= ($urandom_range(0, 3) == 0);
			if (i == n / 2 && $urandom_range(0, 1) == 1)
				settle();
			random_sample();
		end
	endtask

	task automatic run_phase(input int ox, input int oy, input int gx, input int gy,
			input int mnt, input int n);
		logic [15:0]            vals [8];
		logic [CFG_INDEX_W-1:0] idx;
		settle();
		vals[REG_OFFSET_X]    = ox[15:0];
		vals[REG_OFFSET_Y]    = oy[15:0];
		vals[REG_SCALE_X]     = gx[15:0];
		vals[REG_SCALE_Y]     = gy[15:0];
		vals[REG_MOUNT_ANGLE] = mnt[15:0];
		for (int k = int'(REG_MOUNT_ANGLE) + 1; k < 8; k++)
			vals[k] = $urandom;
		for (int k = 0; k < 8; k++) begin
			idx = k[CFG_INDEX_W-1:0];
			cfg_wen   <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= vals[k];
			@(posedge clk);
			sb.set_reg(idx, vals[k]);
		end
		cfg_wen <= 1'b0;
		random_run(n);
	endtask

	initial begin
		sb = new();
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		cfg_wen       <= 1'b0;
		cfg_index     <= REG_OFFSET_X;
		cfg_data      <= '0;
		rush          <= 1'b0;
		idle_cycles   <= 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: offsets -410 / -5038
		send_sample(-16'sd410, -16'sd5038);     // zero vector
		send_sample(16'sd32767, 16'sd32767);
		send_sample(-16'sd32768, -16'sd32768);
		send_sample(16'sd32767, -16'sd32768);
		send_sample(-16'sd32768, 16'sd32767);
		send_sample(16'sd0, 16'sd0);
		send_sample(16'sd1000, -16'sd5038);     // on the +x axis
		send_sample(-16'sd32768, -16'sd5038);   // on the -x axis, gives +pi
		send_sample(-16'sd410, 16'sd32767);
		send_sample(-16'sd410, -16'sd32768);
		send_sample(-16'sd411, -16'sd5039);
		send_sample(-16'sd409, -16'sd5037);
		send_sample(-16'sd411, -16'sd5037);
		send_sample(-16'sd409, -16'sd5039);
		send_sample(-16'sd32768, -16'sd5039);   // just below the -x axis, near -pi
		send_sample(-16'sd32768, -16'sd5037);
		random_run(160);

		run_phase(0, 0, 1024, 1024, 0, 180);
		run_phase(-32768, 32767, 65535, 65535, 12868, 180);
		run_phase(32767, -32768, 1, 65535, -12868, 180);
		run_phase(0, 0, 0, 0, 16383, 40);                   // zero gain on both axes
		run_phase(-1000, 2000, 0, 3000, -16384, 180);
		for (int p = 0; p < 4; p++)
			run_phase($urandom, $urandom,
				($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(256, 4096),
				($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(256, 4096),
				($urandom_range(0, 1) == 1) ? int'($urandom_range(0, 25736)) - 12868
					: int'($urandom_range(0, 32767)) - 16384,
				180);

		settle();
		repeat (LATENCY + 8) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_magnetometer_heading: clean");
		else
			$display("tb_magnetometer_heading: errors");
		$finish;
	end

endmodule
